### sv/nv21q_pkg.sv
// Shared types and constants for the NV21 2x2 block to RGB24 converter.
// Used by every module of the block; depends on nothing else.
package nv21q_pkg;

  // BT.601 coefficients in signed Q3.16 fixed point.
  localparam logic signed [18:0] LUMA_GAIN   = 19'sd76309;
  localparam logic signed [18:0] CR_TO_RED   = 19'sd104597;
  localparam logic signed [18:0] CB_TO_GREEN = 19'sd25675;
  localparam logic signed [18:0] CR_TO_GREEN = 19'sd53279;
  localparam logic signed [18:0] CB_TO_BLUE  = 19'sd132201;

  localparam logic signed [8:0] LUMA_OFFSET   = 9'sd16;
  localparam logic signed [8:0] CHROMA_OFFSET = 9'sd128;
  localparam logic [7:0]        PIXEL_MAX     = 8'd255;

  localparam int unsigned TERM_W   = 28;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned NUM_LANE = 4;

  typedef logic signed [TERM_W-1:0] term_t;

  typedef struct packed {
    term_t red;
    term_t green;
    term_t blue;
  } chroma_terms_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic [7:0] luma_top_left;
    logic [7:0] luma_top_right;
    logic [7:0] luma_bottom_left;
    logic [7:0] luma_bottom_right;
    logic [7:0] chroma_v;
    logic [7:0] chroma_u;
  } in_t;

  typedef struct packed {
    logic [7:0] red_top_left;
    logic [7:0] green_top_left;
    logic [7:0] blue_top_left;
    logic [7:0] red_top_right;
    logic [7:0] green_top_right;
    logic [7:0] blue_top_right;
    logic [7:0] red_bottom_left;
    logic [7:0] green_bottom_left;
    logic [7:0] blue_bottom_left;
    logic [7:0] red_bottom_right;
    logic [7:0] green_bottom_right;
    logic [7:0] blue_bottom_right;
  } out_t;

endpackage

### sv/nv21q_chroma.sv
// Shared chroma stage: registers the four chroma products of a block and
// forms the red, green and blue chroma terms. Depends on nv21q_pkg.
module nv21q_chroma (
  input  logic                    clk,
  input  logic                    load,
  input  logic [7:0]              chroma_v,
  input  logic [7:0]              chroma_u,
  output nv21q_pkg::chroma_terms_t terms
);

  logic signed [8:0] dv;
  logic signed [8:0] du;
  nv21q_pkg::term_t  rv_nxt, gu_nxt, gv_nxt, bu_nxt;
  nv21q_pkg::term_t  rv_r, gu_r, gv_r, bu_r;

  assign dv = $signed({1'b0, chroma_v}) - nv21q_pkg::CHROMA_OFFSET;
  assign du = $signed({1'b0, chroma_u}) - nv21q_pkg::CHROMA_OFFSET;

  always_comb begin
    rv_nxt = nv21q_pkg::term_t'(nv21q_pkg::CR_TO_RED)   * nv21q_pkg::term_t'(dv);
    gu_nxt = nv21q_pkg::term_t'(nv21q_pkg::CB_TO_GREEN) * nv21q_pkg::term_t'(du);
    gv_nxt = nv21q_pkg::term_t'(nv21q_pkg::CR_TO_GREEN) * nv21q_pkg::term_t'(dv);
    bu_nxt = nv21q_pkg::term_t'(nv21q_pkg::CB_TO_BLUE)  * nv21q_pkg::term_t'(du);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rv_r <= rv_nxt;
      gu_r <= gu_nxt;
      gv_r <= gv_nxt;
      bu_r <= bu_nxt;
    end
  end

  always_comb begin
    terms.red   = rv_r;
    terms.green = -gu_r - gv_r;
    terms.blue  = bu_r;
  end

endmodule

### sv/nv21q_lane.sv
// One pixel lane: registers the luma product, then adds the shared chroma
// terms, shifts and clamps to an RGB24 pixel. Depends on nv21q_pkg.
module nv21q_lane (
  input  logic                     clk,
  input  logic                     load,
  input  logic [7:0]               luma,
  input  nv21q_pkg::chroma_terms_t terms,
  output nv21q_pkg::pix_t          pix
);

  localparam int unsigned Q_W = nv21q_pkg::TERM_W - nv21q_pkg::FRAC_W;

  logic signed [8:0] dy;
  nv21q_pkg::term_t  l_nxt;
  nv21q_pkg::term_t  l_r;
  nv21q_pkg::term_t  r_sum, g_sum, b_sum;

  // The top bits of the sum are the floor of sum / 65536; a negative value
  // gives black and anything above 255 gives white.
  function automatic logic [7:0] clamp_pixel(input nv21q_pkg::term_t s);
    logic [Q_W-1:0] q;
    q = s[nv21q_pkg::TERM_W-1:nv21q_pkg::FRAC_W];
    if (q[Q_W-1]) begin
      clamp_pixel = 8'd0;
    end else if (q[Q_W-2:8] != '0) begin
      clamp_pixel = nv21q_pkg::PIXEL_MAX;
    end else begin
      clamp_pixel = q[7:0];
    end
  endfunction

  assign dy    = $signed({1'b0, luma}) - nv21q_pkg::LUMA_OFFSET;
  assign l_nxt = nv21q_pkg::term_t'(nv21q_pkg::LUMA_GAIN) * nv21q_pkg::term_t'(dy);

  always_ff @(posedge clk) begin
    if (load) begin
      l_r <= l_nxt;
    end
  end

  always_comb begin
    r_sum     = l_r + terms.red;
    g_sum     = l_r + terms.green;
    b_sum     = l_r + terms.blue;
    pix.red   = clamp_pixel(r_sum);
    pix.green = clamp_pixel(g_sum);
    pix.blue  = clamp_pixel(b_sum);
  end

endmodule

### sv/nv21_quad_to_rgb24_core.sv
// Top level of the NV21 2x2 block to RGB24 converter: four pixel lanes, the
// shared chroma stage and the output register that merges the lanes.
// Depends on nv21q_pkg, nv21q_chroma and nv21q_lane.
//
//   channel | ports                         | beat
//   --------+-------------------------------+----------------------------------
//   input   | in_valid, in_stall, in_data   | four luma bytes plus V and U
//   result  | out_valid, out_stall, out_data| four RGB24 pixels
//
// One beat enters per cycle unless in_stall is high. A beat is registered in
// the multiplier register, stage one; the lane sums and clamps then feed the output
// register. Reset clears only the two valid flags. While the output register
// is stalled, stage one can still take one beat before in_stall rises.
module nv21_quad_to_rgb24_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  nv21q_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output nv21q_pkg::out_t out_data
);

  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic en_out, en_s1;

  nv21q_pkg::out_t          out_data_r, out_data_nxt;
  nv21q_pkg::chroma_terms_t terms;
  logic [7:0]               luma [nv21q_pkg::NUM_LANE];
  nv21q_pkg::pix_t          pix  [nv21q_pkg::NUM_LANE];

  assign en_out   = !out_valid_r || !out_stall;
  assign en_s1    = !s1_valid_r || en_out;
  assign in_stall = !en_s1;

  assign luma[0] = in_data.luma_top_left;
  assign luma[1] = in_data.luma_top_right;
  assign luma[2] = in_data.luma_bottom_left;
  assign luma[3] = in_data.luma_bottom_right;

  nv21q_chroma u_chroma (
    .clk      (clk),
    .load     (en_s1),
    .chroma_v (in_data.chroma_v),
    .chroma_u (in_data.chroma_u),
    .terms    (terms)
  );

  for (genvar g = 0; g < nv21q_pkg::NUM_LANE; g++) begin : g_lane
    nv21q_lane u_lane (
      .clk   (clk),
      .load  (en_s1),
      .luma  (luma[g]),
      .terms (terms),
      .pix   (pix[g])
    );
  end

  always_comb begin
    out_data_nxt.red_top_left       = pix[0].red;
    out_data_nxt.green_top_left     = pix[0].green;
    out_data_nxt.blue_top_left      = pix[0].blue;
    out_data_nxt.red_top_right      = pix[1].red;
    out_data_nxt.green_top_right    = pix[1].green;
    out_data_nxt.blue_top_right     = pix[1].blue;
    out_data_nxt.red_bottom_left    = pix[2].red;
    out_data_nxt.green_bottom_left  = pix[2].green;
    out_data_nxt.blue_bottom_left   = pix[2].blue;
    out_data_nxt.red_bottom_right   = pix[3].red;
    out_data_nxt.green_bottom_right = pix[3].green;
    out_data_nxt.blue_bottom_right  = pix[3].blue;
  end

  always_comb begin
    s1_valid_nxt  = en_s1  ? in_valid   : s1_valid_r;
    out_valid_nxt = en_out ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### sv/nv21q_checker.sv
// Port-level checks for nv21_quad_to_rgb24_core, bound to the top level.
// Depends on nv21q_pkg and the top level's port list.
module nv21q_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_stall,
  input nv21q_pkg::in_t  in_data,
  input logic            out_valid,
  input logic            out_stall,
  input nv21q_pkg::out_t out_data
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // After reset no result beat is offered.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // The input only stalls when a result is held back.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // An accepted beat reaches the output register when nothing stalls.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
    else $error("accepted beat did not reach the output");

endmodule

bind nv21_quad_to_rgb24_core nv21q_checker u_nv21q_checker (.*);
